FILE: rtl/priority_scheduler_wait_times_assert.svh
// Assertion macros for the checker module of the scheduler.
`ifndef PRIORITY_SCHEDULER_WAIT_TIMES_ASSERT_SVH
`define PRIORITY_SCHEDULER_WAIT_TIMES_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define PSW_ASSERT_SAME(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define PSW_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: rtl/psw_pkg.sv
`timescale 1ns / 1ps
package psw_pkg;

    localparam int PRI_W   = 8;
    localparam int BURST_W = 16;
    localparam int NUM_W   = 5;
    localparam int TIME_W  = 20;

    typedef struct packed {
        logic [PRI_W-1:0]   priority_req;
        logic [BURST_W-1:0] burst_time;
        logic               last_job;
    } t_job_in;

    typedef struct packed {
        logic [NUM_W-1:0]   job_number;
        logic [PRI_W-1:0]   job_priority;
        logic [BURST_W-1:0] job_burst;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround;
        logic               overflowed;
        logic               last_result;
    } t_job_out;

    // One stored job as it sits in a chain cell.
    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [PRI_W-1:0]   prio;
        logic [BURST_W-1:0] burst;
    } t_job;

    // Chain control, common to every cell.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

FILE: rtl/psw_cell.sv
`timescale 1ns / 1ps
module psw_cell
    import psw_pkg::*;
#(
    parameter int MAX_JOBS = 16,
    parameter int IDX      = 0
) (
    input  logic                           i_clk,
    input  t_cell_ctl                      i_ctl,
    input  logic [$clog2(MAX_JOBS+1)-1:0]  i_count,
    input  t_job                           i_new,
    input  t_job                           i_left,
    input  logic                           i_left_ins,
    input  t_job                           i_right,
    output t_job                           o_job,
    output logic                           o_ins
);

    localparam int CW = $clog2(MAX_JOBS + 1);

    t_job r_job;
    t_job n_job;
    logic w_after;

    // Empty cells and cells with a strictly larger priority give way;
    // equal priorities stay ahead of the new job.
    assign w_after = (CW'(IDX) >= i_count) || (r_job.prio > i_new.prio);
    assign o_ins   = i_left_ins || w_after;
    assign o_job   = r_job;

    always_comb begin
        n_job = r_job;
        if (i_ctl.shift) begin
            n_job = i_right;
        end else if (i_ctl.load) begin
            if (i_left_ins) begin
                n_job = i_left;
            end else if (w_after) begin
                n_job = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

FILE: rtl/priority_scheduler_wait_times.sv
`timescale 1ns / 1ps
// Loading: one job per cycle, busy stays low while jobs are loaded into the sorting chain.
// On the transfer marked last, busy goes high until all stored jobs (up to MAX_JOBS) are out;
// the chain shifts one cell toward the output each cycle, so results come one per cycle.
// After the last transfer, r_drain and then r_strobe rise; the results cannot be stalled.
// Reset (synchronous, active low) empties the batch and clears the overflow flag.
module priority_scheduler_wait_times
    import psw_pkg::*;
#(
    parameter int MAX_JOBS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_job_in  i_job,
    output logic     busy,
    output logic     o_strobe,
    output t_job_out o_result
);

    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [CW-1:0]     r_count;
    logic              r_ovf;
    logic              r_drain;
    logic              r_strobe;
    logic [TIME_W-1:0] r_wait;
    t_job_out          r_out;

    logic              w_accept;
    logic              w_store;
    logic [TIME_W:0]   w_tat_sum;
    logic [TIME_W-1:0] n_wait;
    t_cell_ctl         w_ctl;
    t_job              w_new;

    t_job w_cell_job [MAX_JOBS];
    logic w_cell_ins [MAX_JOBS];

    assign w_accept = start && !r_drain;
    assign w_store  = w_accept && (r_count < CW'(MAX_JOBS));

    assign w_ctl.load  = w_store;
    assign w_ctl.shift = r_drain;

    assign w_new.number = NUM_W'(r_count + CW'(1));
    assign w_new.prio   = i_job.priority_req;
    assign w_new.burst  = i_job.burst_time;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
            t_job w_left;
            t_job w_right;
            logic w_left_ins;
            if (gi == 0) begin : g_first
                assign w_left     = w_new;
                assign w_left_ins = 1'b0;
            end else begin : g_mid
                assign w_left     = w_cell_job[gi-1];
                assign w_left_ins = w_cell_ins[gi-1];
            end
            if (gi == MAX_JOBS - 1) begin : g_end
                assign w_right = w_new;
            end else begin : g_inner
                assign w_right = w_cell_job[gi+1];
            end
            psw_cell #(
                .MAX_JOBS (MAX_JOBS),
                .IDX      (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_count    (r_count),
                .i_new      (w_new),
                .i_left     (w_left),
                .i_left_ins (w_left_ins),
                .i_right    (w_right),
                .o_job      (w_cell_job[gi]),
                .o_ins      (w_cell_ins[gi])
            );
        end
    endgenerate

    // Saturate the running time at the field limit.
    assign w_tat_sum = {1'b0, r_wait} + (TIME_W + 1)'(w_cell_job[0].burst);
    assign n_wait    = w_tat_sum[TIME_W] ? {TIME_W{1'b1}} : w_tat_sum[TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_drain  <= 1'b0;
            r_strobe <= 1'b0;
            r_wait   <= '0;
        end else begin
            r_strobe <= r_drain;
            if (r_drain) begin
                r_count <= r_count - CW'(1);
                r_wait  <= n_wait;
                if (r_count <= CW'(1)) begin
                    r_drain <= 1'b0;
                    r_ovf   <= 1'b0;
                    r_wait  <= '0;
                    r_count <= '0;
                end
            end else if (w_accept) begin
                if (w_store) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_job.last_job) begin
                    r_drain <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_drain) begin
            r_out.job_number   <= w_cell_job[0].number;
            r_out.job_priority <= w_cell_job[0].prio;
            r_out.job_burst    <= w_cell_job[0].burst;
            r_out.wait_time    <= r_wait;
            r_out.turnaround   <= n_wait;
            r_out.overflowed   <= r_ovf;
            r_out.last_result  <= (r_count == CW'(1));
        end
    end

    assign busy     = r_drain;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

FILE: rtl/psw_checker.sv
`timescale 1ns / 1ps
`include "priority_scheduler_wait_times_assert.svh"
module psw_checker
    import psw_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input t_job_in  i_job,
    input logic     busy,
    input logic     o_strobe,
    input t_job_out o_result
);

    logic w_xfer;
    logic w_last_xfer;
    logic w_plain_xfer;
    logic w_mid_result;
    logic w_tat_ok;

    assign w_xfer       = start && !busy;
    assign w_last_xfer  = w_xfer && i_job.last_job;
    assign w_plain_xfer = w_xfer && !i_job.last_job;
    assign w_mid_result = o_strobe && !o_result.last_result;
    assign w_tat_ok     = o_result.turnaround >= o_result.wait_time;

    `PSW_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, w_last_xfer, busy, "drain did not start")
    `PSW_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, w_plain_xfer, !busy, "busy after a plain load")
    `PSW_ASSERT_SAME(a_strobe_src, i_clk, i_rst_n, o_strobe, $past(busy), "result without drain")
    `PSW_ASSERT_NEXT(a_burst_run, i_clk, i_rst_n, w_mid_result, o_strobe, "gap in result burst")
    `PSW_ASSERT_SAME(a_tat_order, i_clk, i_rst_n, o_strobe, w_tat_ok, "turnaround below wait")

endmodule

bind priority_scheduler_wait_times psw_checker u_psw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_job    (i_job),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
